[sv/drk4_pkg.sv]
// drk4_pkg: shared types, constants and helpers for the rk4 drag flight step
// no dependencies; used by drk4_ctrl, drk4_datapath and drag_descent_rk4_step

package drk4_pkg;

   // datapath widths
   localparam int DATA_W    = 32;
   localparam int MUL_A_W   = 34;
   localparam int MUL_B_W   = 32;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int SUM_W     = 36;
   localparam int DIV_W     = 51;
   localparam int DIV_STEPS = (DIV_W + 7) / 8;
   localparam int DIV_PAD   = DIV_STEPS * 8;
   localparam int DIV_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
   localparam int CSR_IDX_W = 4;
   localparam int TSTEP_W   = 17;

   localparam logic [63:0] DRAG_CLAMP = 64'h0000_0100_0000_0000;
   localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] SAT_LO = -64'sh0000_0000_8000_0000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY     = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DRAG_ASCENT = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DRAG_DROGUE = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DRAG_MAIN   = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPLOY_ALT  = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_START_ALT   = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_START_VEL   = 4'd7;

   // register reset values
   localparam logic [TSTEP_W-1:0]       RST_TIME_STEP   = 17'd3277;
   localparam logic signed [DATA_W-1:0] RST_GRAVITY     = -32'sd642253;
   localparam logic [DATA_W-1:0]        RST_DRAG_ASCENT = 32'd868000;
   localparam logic [DATA_W-1:0]        RST_DRAG_DROGUE = 32'd3010000;
   localparam logic [DATA_W-1:0]        RST_DRAG_MAIN   = 32'd8404000;
   localparam logic signed [DATA_W-1:0] RST_DEPLOY_ALT  = 32'sd78643200;
   localparam logic signed [DATA_W-1:0] RST_START_ALT   = 32'sd46085324;
   localparam logic signed [DATA_W-1:0] RST_START_VEL   = 32'sd19070976;

   // rk4 stage numbers: k1..k4, then the closing acceleration
   localparam logic [2:0] STAGE_K1 = 3'd0;
   localparam logic [2:0] STAGE_K3 = 3'd2;
   localparam logic [2:0] STAGE_K4 = 3'd3;
   localparam logic [2:0] STAGE_NA = 3'd4;

   typedef enum logic [1:0] {
      PH_ASCENT = 2'd0,
      PH_DROGUE = 2'd1,
      PH_MAIN   = 2'd2
   } phase_type;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_LOAD,
      OP_SQ,
      OP_HI,
      OP_LO,
      OP_SUM,
      OP_FIN,
      OP_SCALE,
      OP_STEP,
      OP_VACC,
      OP_KACC,
      OP_MULK,
      OP_MULV,
      OP_DLOAD,
      OP_DIV,
      OP_APPV,
      OP_APPP,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [2:0] stage;
   } cmd_type;

   typedef struct packed {
      logic last;
   } status_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
      if (x > SAT_HI) begin
         return DATA_W'(SAT_HI);
      end else if (x < SAT_LO) begin
         return DATA_W'(SAT_LO);
      end
      return x[DATA_W-1:0];
   endfunction

   function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] x);
      return x[DATA_W-1] ? (~x + 32'd1) : x;
   endfunction

   function automatic logic [SUM_W-1:0] mag36(input logic signed [SUM_W-1:0] x);
      return x[SUM_W-1] ? (~x + 36'd1) : x;
   endfunction

endpackage

[sv/drk4_ctrl.sv]
// drk4_ctrl: sequencer for one rk4 step over the shared multiplier
// depends on drk4_pkg; drives drk4_datapath through cmd_type

module drk4_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_advance,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  drk4_pkg::status_type  status,
   output drk4_pkg::cmd_type     cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_LOAD, S_SQ, S_HI, S_LO, S_SUM, S_FIN, S_SCALE, S_STEP, S_VACC,
      S_KACC, S_MULK, S_MULV, S_DLOAD, S_DIV, S_APPV, S_APPP, S_OUT
   } state_type;

   state_type                        state_ff;
   logic [2:0]                       stage_ff;
   logic                             sel_ff;
   logic [drk4_pkg::DIV_CNT_W-1:0]   div_cnt_ff;
   logic                             finished_ff;
   logic                             rsp_valid_ff;

   logic start;
   logic can_out;

   assign start     = (state_ff == S_IDLE) && req_valid && req_advance && !finished_ff;
   assign can_out   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.stage = stage_ff;
      unique case (state_ff)
         S_IDLE:  cmd.op = drk4_pkg::OP_NOP;
         S_LOAD:  cmd.op = drk4_pkg::OP_LOAD;
         S_SQ:    cmd.op = drk4_pkg::OP_SQ;
         S_HI:    cmd.op = drk4_pkg::OP_HI;
         S_LO:    cmd.op = drk4_pkg::OP_LO;
         S_SUM:   cmd.op = drk4_pkg::OP_SUM;
         S_FIN:   cmd.op = drk4_pkg::OP_FIN;
         S_SCALE: cmd.op = drk4_pkg::OP_SCALE;
         S_STEP:  cmd.op = drk4_pkg::OP_STEP;
         S_VACC:  cmd.op = drk4_pkg::OP_VACC;
         S_KACC:  cmd.op = drk4_pkg::OP_KACC;
         S_MULK:  cmd.op = drk4_pkg::OP_MULK;
         S_MULV:  cmd.op = drk4_pkg::OP_MULV;
         S_DLOAD: cmd.op = drk4_pkg::OP_DLOAD;
         S_DIV:   cmd.op = drk4_pkg::OP_DIV;
         S_APPV:  cmd.op = drk4_pkg::OP_APPV;
         S_APPP:  cmd.op = drk4_pkg::OP_APPP;
         S_OUT:   cmd.op = can_out ? drk4_pkg::OP_OUT : drk4_pkg::OP_NOP;
         default: cmd.op = drk4_pkg::OP_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stage_ff     <= drk4_pkg::STAGE_K1;
         sel_ff       <= 1'b0;
         div_cnt_ff   <= '0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in S_OUT the valid flag is handled by the output load below
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_LOAD;
                  stage_ff <= drk4_pkg::STAGE_K1;
               end
            end
            S_LOAD:  state_ff <= S_SQ;
            S_SQ:    state_ff <= S_HI;
            S_HI:    state_ff <= S_LO;
            S_LO:    state_ff <= S_SUM;
            S_SUM:   state_ff <= S_FIN;
            S_FIN: begin
               if (stage_ff < drk4_pkg::STAGE_K4) begin
                  state_ff <= S_SCALE;
               end else if (stage_ff == drk4_pkg::STAGE_K4) begin
                  state_ff <= S_KACC;
               end else begin
                  state_ff <= S_OUT;
               end
            end
            S_SCALE: state_ff <= S_STEP;
            S_STEP:  state_ff <= S_VACC;
            S_VACC: begin
               stage_ff <= stage_ff + 3'd1;
               state_ff <= S_SQ;
            end
            S_KACC: begin
               sel_ff   <= 1'b0;
               state_ff <= S_MULK;
            end
            S_MULK:  state_ff <= S_DLOAD;
            S_MULV:  state_ff <= S_DLOAD;
            S_DLOAD: begin
               div_cnt_ff <= '0;
               state_ff   <= S_DIV;
            end
            S_DIV: begin
               if (div_cnt_ff == drk4_pkg::DIV_CNT_W'(drk4_pkg::DIV_STEPS - 1)) begin
                  state_ff <= sel_ff ? S_APPP : S_APPV;
               end else begin
                  div_cnt_ff <= div_cnt_ff + 1'b1;
               end
            end
            S_APPV: begin
               sel_ff   <= 1'b1;
               state_ff <= S_MULV;
            end
            S_APPP: begin
               stage_ff <= drk4_pkg::STAGE_NA;
               state_ff <= S_SQ;
            end
            S_OUT: begin
               if (can_out) begin
                  rsp_valid_ff <= 1'b1;
                  finished_ff  <= finished_ff | status.last;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_out_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && can_out) |=> rsp_valid_ff)
      else $error("result not presented after output load");

   a_finished_sticks: assert property (@(posedge clock) disable iff (reset)
      finished_ff |=> finished_ff)
      else $error("finished flag dropped");

   a_div_count_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_cnt_ff < drk4_pkg::DIV_CNT_W'(drk4_pkg::DIV_STEPS)))
      else $error("divider step count out of range");

   a_stage_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (stage_ff <= drk4_pkg::STAGE_NA))
      else $error("rk4 stage out of range");
`endif

endmodule

[sv/drk4_datapath.sv]
// drk4_datapath: flight state, registers, shared multiplier and divide-by-six unit
// depends on drk4_pkg; sequenced by drk4_ctrl

module drk4_datapath #(
   parameter int MAX_STEPS = 4096,
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  drk4_pkg::cmd_type                    cmd,
   output drk4_pkg::status_type                 status,
   input  logic                                 csr_write,
   input  logic [drk4_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [drk4_pkg::DATA_W-1:0]          csr_wdata,
   output logic [11:0]                          rsp_step_index,
   output logic signed [drk4_pkg::DATA_W-1:0]   rsp_altitude,
   output logic signed [drk4_pkg::DATA_W-1:0]   rsp_vertical_velocity,
   output logic signed [drk4_pkg::DATA_W-1:0]   rsp_vertical_accel,
   output logic [1:0]                           rsp_drag_phase,
   output logic                                 rsp_apogee_pulse,
   output logic signed [drk4_pkg::DATA_W-1:0]   rsp_apogee_altitude,
   output logic                                 rsp_last_step
);

   localparam int DW    = drk4_pkg::DATA_W;
   localparam int SW    = drk4_pkg::SUM_W;
   localparam int CNT_W = $clog2(MAX_STEPS);

   // configuration
   logic [drk4_pkg::TSTEP_W-1:0] h_ff, h_in;
   logic signed [DW-1:0]         g_ff, g_in;
   logic [DW-1:0]                kasc_ff, kasc_in, kdro_ff, kdro_in, kmain_ff, kmain_in;
   logic signed [DW-1:0]         deploy_ff, deploy_in;

   // flight state
   logic signed [DW-1:0]  p_ff, p_in, v_ff, v_in;
   drk4_pkg::phase_type   phase_ff, phase_in;
   logic                  apo_ff, apo_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   // working registers
   logic [DW-1:0]                    k_ff, k_in;
   logic signed [DW-1:0]             x_ff, x_in, a_ff, a_in;
   logic [drk4_pkg::PROD_W-1:0]      prod_ff, prod_in;
   logic [DW-1:0]                    lo_ff, lo_in;
   logic [63:0]                      d_ff, d_in;
   logic signed [SW-1:0]             ksum_ff, ksum_in, vsum_ff, vsum_in;
   logic                             sgn_ff, sgn_in;
   logic [drk4_pkg::DIV_PAD-1:0]     dq_ff, dq_in;
   logic [2:0]                       rem_ff, rem_in;

   // captured at load
   logic [CNT_W-1:0]      cidx_ff, cidx_in;
   logic                  cpulse_ff, cpulse_in, clast_ff, clast_in;
   logic signed [DW-1:0]  capo_ff, capo_in;

   // result register
   logic [11:0]           o_idx_ff, o_idx_in;
   logic signed [DW-1:0]  o_p_ff, o_p_in, o_v_ff, o_v_in, o_a_ff, o_a_in, o_apo_ff, o_apo_in;
   logic [1:0]            o_ph_ff, o_ph_in;
   logic                  o_pulse_ff, o_pulse_in, o_last_ff, o_last_in;

   logic [drk4_pkg::MUL_A_W-1:0] mul_a;
   logic [drk4_pkg::MUL_B_W-1:0] mul_b;

   assign status.last  = clast_ff;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         drk4_pkg::OP_SQ: begin
            mul_a = drk4_pkg::MUL_A_W'(drk4_pkg::mag32(x_ff));
            mul_b = drk4_pkg::mag32(x_ff);
         end
         drk4_pkg::OP_HI: begin
            mul_a = drk4_pkg::MUL_A_W'(prod_ff[63:32]);
            mul_b = k_ff;
         end
         drk4_pkg::OP_LO: begin
            mul_a = drk4_pkg::MUL_A_W'(lo_ff);
            mul_b = k_ff;
         end
         drk4_pkg::OP_SCALE: begin
            mul_a = drk4_pkg::MUL_A_W'(drk4_pkg::mag32(a_ff));
            mul_b = drk4_pkg::MUL_B_W'(h_ff);
         end
         drk4_pkg::OP_MULK: begin
            mul_a = drk4_pkg::MUL_A_W'(drk4_pkg::mag36(ksum_ff));
            mul_b = drk4_pkg::MUL_B_W'(h_ff);
         end
         drk4_pkg::OP_MULV: begin
            mul_a = drk4_pkg::MUL_A_W'(drk4_pkg::mag36(vsum_ff));
            mul_b = drk4_pkg::MUL_B_W'(h_ff);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      logic [63:0]          dsh;
      logic [63:0]          dcl;
      logic signed [63:0]   g64, v64, p64, term, wide;
      logic [48:0]          shv;
      logic                 x_pos;
      logic                 pulse;
      logic [drk4_pkg::DIV_W-1:0]   quo;
      logic [drk4_pkg::DIV_PAD-1:0] dq;
      logic [2:0]           r;
      logic [3:0]           t;
      logic [CNT_W+11:0]    idx_ext;

      h_in = h_ff;   g_in = g_ff;   kasc_in = kasc_ff;   kdro_in = kdro_ff;
      kmain_in = kmain_ff;   deploy_in = deploy_ff;
      p_in = p_ff;   v_in = v_ff;   phase_in = phase_ff;   apo_in = apo_ff;   cnt_in = cnt_ff;
      k_in = k_ff;   x_in = x_ff;   a_in = a_ff;   lo_in = lo_ff;   d_in = d_ff;
      ksum_in = ksum_ff;   vsum_in = vsum_ff;   sgn_in = sgn_ff;
      dq_in = dq_ff;   rem_in = rem_ff;
      cidx_in = cidx_ff;   cpulse_in = cpulse_ff;   clast_in = clast_ff;   capo_in = capo_ff;
      o_idx_in = o_idx_ff;   o_p_in = o_p_ff;   o_v_in = o_v_ff;   o_a_in = o_a_ff;
      o_apo_in = o_apo_ff;   o_ph_in = o_ph_ff;   o_pulse_in = o_pulse_ff;
      o_last_in = o_last_ff;
      prod_in = drk4_pkg::PROD_W'(mul_a) * drk4_pkg::PROD_W'(mul_b);

      g64   = 64'(g_ff);
      v64   = 64'(v_ff);
      p64   = 64'(p_ff);
      x_pos = !x_ff[DW-1] && (x_ff != '0);
      dsh   = d_ff >> FRAC_BITS;
      dcl   = (dsh > drk4_pkg::DRAG_CLAMP) ? drk4_pkg::DRAG_CLAMP : dsh;
      shv   = (cmd.stage < drk4_pkg::STAGE_K3) ? (prod_ff[48:0] >> (FRAC_BITS + 1))
                                               : (prod_ff[48:0] >> FRAC_BITS);
      quo   = dq_ff[drk4_pkg::DIV_W-1:0];
      term  = '0;
      wide  = '0;
      pulse = 1'b0;
      dq    = dq_ff;
      r     = rem_ff;
      t     = '0;
      idx_ext = {12'd0, cidx_ff};

      case (cmd.op)
         drk4_pkg::OP_LOAD: begin
            if (v_ff[DW-1]) begin
               pulse    = !apo_ff;
               apo_in   = 1'b1;
               phase_in = (p_ff < deploy_ff) ? drk4_pkg::PH_MAIN : drk4_pkg::PH_DROGUE;
            end
            unique case (phase_in)
               drk4_pkg::PH_ASCENT: k_in = kasc_ff;
               drk4_pkg::PH_DROGUE: k_in = kdro_ff;
               default:             k_in = kmain_ff;
            endcase
            x_in      = v_ff;
            vsum_in   = SW'(v_ff);
            ksum_in   = '0;
            cidx_in   = cnt_ff;
            cnt_in    = cnt_ff + 1'b1;
            cpulse_in = pulse;
            capo_in   = pulse ? p_ff : '0;
            clast_in  = p_ff[DW-1] || (cnt_ff == CNT_W'(MAX_STEPS - 1));
         end
         drk4_pkg::OP_HI:  lo_in = prod_ff[31:0];
         drk4_pkg::OP_LO:  d_in  = prod_ff[63:0];
         drk4_pkg::OP_SUM: d_in  = d_ff + {32'd0, prod_ff[63:32]};
         drk4_pkg::OP_FIN: begin
            wide = x_pos ? (g64 - $signed(dcl)) : (g64 + $signed(dcl));
            a_in = drk4_pkg::sat32(wide);
         end
         drk4_pkg::OP_SCALE: begin
            ksum_in = (cmd.stage == drk4_pkg::STAGE_K1) ? (ksum_ff + SW'(a_ff))
                                                        : (ksum_ff + (SW'(a_ff) <<< 1));
         end
         drk4_pkg::OP_STEP: begin
            term = $signed({15'd0, shv});
            wide = a_ff[DW-1] ? (v64 - term) : (v64 + term);
            x_in = drk4_pkg::sat32(wide);
         end
         drk4_pkg::OP_VACC: begin
            vsum_in = (cmd.stage == drk4_pkg::STAGE_K3) ? (vsum_ff + SW'(x_ff))
                                                        : (vsum_ff + (SW'(x_ff) <<< 1));
         end
         drk4_pkg::OP_KACC: ksum_in = ksum_ff + SW'(a_ff);
         drk4_pkg::OP_MULK: sgn_in  = ksum_ff[SW-1];
         drk4_pkg::OP_MULV: sgn_in  = vsum_ff[SW-1];
         drk4_pkg::OP_DLOAD: begin
            dq_in  = drk4_pkg::DIV_PAD'(prod_ff[drk4_pkg::DIV_W-1:0] >> FRAC_BITS);
            rem_in = '0;
         end
         drk4_pkg::OP_DIV: begin
            // eight restoring steps of division by six
            for (int i = 0; i < 8; i++) begin
               t  = {r, dq[drk4_pkg::DIV_PAD-1]};
               dq = {dq[drk4_pkg::DIV_PAD-2:0], 1'b0};
               if (t >= 4'd6) begin
                  r     = 3'(t - 4'd6);
                  dq[0] = 1'b1;
               end else begin
                  r = t[2:0];
               end
            end
            dq_in  = dq;
            rem_in = r;
         end
         drk4_pkg::OP_APPV: begin
            term = $signed(64'(quo));
            wide = sgn_ff ? (v64 - term) : (v64 + term);
            v_in = drk4_pkg::sat32(wide);
            x_in = v_in;
         end
         drk4_pkg::OP_APPP: begin
            term = $signed(64'(quo));
            wide = sgn_ff ? (p64 - term) : (p64 + term);
            p_in = drk4_pkg::sat32(wide);
         end
         drk4_pkg::OP_OUT: begin
            o_idx_in   = idx_ext[11:0];
            o_p_in     = p_ff;
            o_v_in     = v_ff;
            o_a_in     = a_ff;
            o_ph_in    = phase_ff;
            o_pulse_in = cpulse_ff;
            o_apo_in   = capo_ff;
            o_last_in  = clast_ff;
         end
         default: begin
         end
      endcase

      if (csr_write) begin
         case (csr_index)
            drk4_pkg::CSR_TIME_STEP:   h_in      = csr_wdata[drk4_pkg::TSTEP_W-1:0];
            drk4_pkg::CSR_GRAVITY:     g_in      = csr_wdata;
            drk4_pkg::CSR_DRAG_ASCENT: kasc_in   = csr_wdata;
            drk4_pkg::CSR_DRAG_DROGUE: kdro_in   = csr_wdata;
            drk4_pkg::CSR_DRAG_MAIN:   kmain_in  = csr_wdata;
            drk4_pkg::CSR_DEPLOY_ALT:  deploy_in = csr_wdata;
            drk4_pkg::CSR_START_ALT:   p_in      = csr_wdata;
            drk4_pkg::CSR_START_VEL:   v_in      = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff      <= drk4_pkg::RST_TIME_STEP;
         g_ff      <= drk4_pkg::RST_GRAVITY;
         kasc_ff   <= drk4_pkg::RST_DRAG_ASCENT;
         kdro_ff   <= drk4_pkg::RST_DRAG_DROGUE;
         kmain_ff  <= drk4_pkg::RST_DRAG_MAIN;
         deploy_ff <= drk4_pkg::RST_DEPLOY_ALT;
         p_ff      <= drk4_pkg::RST_START_ALT;
         v_ff      <= drk4_pkg::RST_START_VEL;
         phase_ff  <= drk4_pkg::PH_ASCENT;
         apo_ff    <= 1'b0;
         cnt_ff    <= '0;
         clast_ff  <= 1'b0;
      end else begin
         h_ff      <= h_in;
         g_ff      <= g_in;
         kasc_ff   <= kasc_in;
         kdro_ff   <= kdro_in;
         kmain_ff  <= kmain_in;
         deploy_ff <= deploy_in;
         p_ff      <= p_in;
         v_ff      <= v_in;
         phase_ff  <= phase_in;
         apo_ff    <= apo_in;
         cnt_ff    <= cnt_in;
         clast_ff  <= clast_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      k_ff       <= k_in;
      x_ff       <= x_in;
      a_ff       <= a_in;
      prod_ff    <= prod_in;
      lo_ff      <= lo_in;
      d_ff       <= d_in;
      ksum_ff    <= ksum_in;
      vsum_ff    <= vsum_in;
      sgn_ff     <= sgn_in;
      dq_ff      <= dq_in;
      rem_ff     <= rem_in;
      cidx_ff    <= cidx_in;
      cpulse_ff  <= cpulse_in;
      capo_ff    <= capo_in;
      o_idx_ff   <= o_idx_in;
      o_p_ff     <= o_p_in;
      o_v_ff     <= o_v_in;
      o_a_ff     <= o_a_in;
      o_apo_ff   <= o_apo_in;
      o_ph_ff    <= o_ph_in;
      o_pulse_ff <= o_pulse_in;
      o_last_ff  <= o_last_in;
   end

   assign rsp_step_index        = o_idx_ff;
   assign rsp_altitude          = o_p_ff;
   assign rsp_vertical_velocity = o_v_ff;
   assign rsp_vertical_accel    = o_a_ff;
   assign rsp_drag_phase        = o_ph_ff;
   assign rsp_apogee_pulse      = o_pulse_ff;
   assign rsp_apogee_altitude   = o_apo_ff;
   assign rsp_last_step         = o_last_ff;

endmodule

[sv/drag_descent_rk4_step.sv]
// drag_descent_rk4_step: top level of the rk4 vertical flight stepper
// depends on drk4_pkg, drk4_ctrl and drk4_datapath

// Each accepted request with advance set moves the flight state on by one
// classic RK4 step, a(v) = g - k*v*|v|, in signed Q16.16 with saturation. The
// block works on one request at a time and takes the next only once the step
// has reached the result register. The pace is set by the single shared 34x32
// multiplier that the controller walks through four drag evaluations, three
// stage updates and two weighted sums, plus the closing drag evaluation, and
// by the divide-by-six unit that retires eight quotient bits a cycle for each
// of the two final updates. req_stall is low only while idle; a result
// waiting in the output register does not block the next request, only the
// end of the step that follows it. A request with advance clear, or any
// request after the landing or step-limit step, is taken and gives no
// result. Writing start altitude or velocity loads the flight state at once;
// there is no clearing pass after reset.

module drag_descent_rk4_step #(
   parameter int MAX_STEPS = 4096,
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_advance,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [11:0]                          rsp_step_index,
   output logic signed [drk4_pkg::DATA_W-1:0]   rsp_altitude,
   output logic signed [drk4_pkg::DATA_W-1:0]   rsp_vertical_velocity,
   output logic signed [drk4_pkg::DATA_W-1:0]   rsp_vertical_accel,
   output logic [1:0]                           rsp_drag_phase,
   output logic                                 rsp_apogee_pulse,
   output logic signed [drk4_pkg::DATA_W-1:0]   rsp_apogee_altitude,
   output logic                                 rsp_last_step,
   // register write port
   input  logic                                 csr_write,
   input  logic [drk4_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [drk4_pkg::DATA_W-1:0]          csr_wdata
);

   drk4_pkg::cmd_type    cmd;
   drk4_pkg::status_type status;

   // sequencer: owns the handshakes and the finished flag
   drk4_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_advance (req_advance),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   // arithmetic, flight state, registers and the result register
   drk4_datapath #(
      .MAX_STEPS (MAX_STEPS),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .rsp_step_index        (rsp_step_index),
      .rsp_altitude          (rsp_altitude),
      .rsp_vertical_velocity (rsp_vertical_velocity),
      .rsp_vertical_accel    (rsp_vertical_accel),
      .rsp_drag_phase        (rsp_drag_phase),
      .rsp_apogee_pulse      (rsp_apogee_pulse),
      .rsp_apogee_altitude   (rsp_apogee_altitude),
      .rsp_last_step         (rsp_last_step)
   );

endmodule
